>>> hdl/falc_pkg.sv
package falc_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int BLOCK_WORDS = 32;
  localparam int SLOT_W      = 8;
  localparam int WIDX_W      = 5;
  localparam int STAMP_W     = 32;
  localparam int DISK_W      = 4;
  localparam int BLK_W       = 8;
  localparam int CFG_W       = 9;
  localparam int TAG_W       = DISK_W + BLK_W + STAMP_W;
  localparam int BADDR_W     = SLOT_W + WIDX_W;

  localparam logic [STAMP_W-1:0] STAMP_LIMIT = 32'h7FFF_FFFF;

  localparam logic [1:0] FUNC_LOOKUP  = 2'd0;
  localparam logic [1:0] FUNC_INSERT  = 2'd1;
  localparam logic [1:0] FUNC_UPDATE  = 2'd2;
  localparam logic [1:0] FUNC_IGNORED = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_DISABLED = 2'd2;
  localparam logic [1:0] ST_PRESENT  = 2'd3;

  localparam logic REG_ENABLE  = 1'b0;
  localparam logic REG_ENTRIES = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_COPY,
    S_READ
  } state_t;

endpackage

>>> hdl/fully_assoc_lru_block_cache_core.sv
// Lookup: tag scan over the configured entry count (n = entries, clamped to 2..256;
// one slot per cycle through the tag memory read port), then 32 result beats on a hit.
// Insert/update on the last beat: tag scan, then a staging buffer copy (insert, or update hit).
// Intermediate beats only write the staging buffer; one item at a time, the receiver cannot stall.
// Reset (rst, synchronous) clears valid marks, the use counter, enable and done, sets
// entries to 2 and idles; tag, stamp, block, staging memories and datapath regs are not cleared.
module fully_assoc_lru_block_cache_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [3:0]  disk,
  input  logic [7:0]  block_number,
  input  logic [4:0]  word_index,
  input  logic [63:0] data_word,
  input  logic        last_word,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [8:0]  wr_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [7:0]  slot,
  output logic [4:0]  word_out_index,
  output logic [63:0] data_out,
  output logic        last_out
);

  falc_pkg::state_t state, state_next;

  logic                           enable;
  logic [falc_pkg::CFG_W-1:0]     entries;
  logic [falc_pkg::MAX_ENTRIES-1:0] valid;
  logic [falc_pkg::STAMP_W-1:0]   counter;

  logic [falc_pkg::TAG_W-1:0]     tag_mem [falc_pkg::MAX_ENTRIES];
  logic [63:0]                    blk_mem [falc_pkg::MAX_ENTRIES*falc_pkg::BLOCK_WORDS];
  logic [63:0]                    stg_mem [falc_pkg::BLOCK_WORDS];

  logic [1:0]                     func_r;
  logic [falc_pkg::DISK_W-1:0]    disk_r;
  logic [falc_pkg::BLK_W-1:0]     blk_r;

  logic [falc_pkg::CFG_W-1:0]     rd_idx;
  logic                           cmp_vld;
  logic [falc_pkg::SLOT_W-1:0]    cmp_idx;
  logic [falc_pkg::TAG_W-1:0]     tag_q;
  logic                           hit;
  logic [falc_pkg::SLOT_W-1:0]    hit_slot;
  logic                           free_ok;
  logic [falc_pkg::SLOT_W-1:0]    free_idx;
  logic [falc_pkg::STAMP_W-1:0]   oldest;
  logic [falc_pkg::SLOT_W-1:0]    old_idx;
  logic [falc_pkg::SLOT_W-1:0]    tgt;
  logic [1:0]                     res_status;
  logic [5:0]                     cnt;
  logic [63:0]                    stg_q;
  logic [63:0]                    bs_q;
  logic                           out_sel;

  logic [falc_pkg::SLOT_W-1:0]    n_m1;
  logic                           accept, go, tick, rd_issue, match, scan_end;
  logic [falc_pkg::DISK_W-1:0]    q_disk;
  logic [falc_pkg::BLK_W-1:0]     q_blk;
  logic [falc_pkg::STAMP_W-1:0]   q_stamp;
  logic [falc_pkg::SLOT_W-1:0]    act_tgt;

  assign busy     = (state != falc_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign data_out = out_sel ? bs_q : 64'd0;

  always_comb begin
    if (entries < 9'd2) n_m1 = 8'd1;
    else if (entries > 9'(falc_pkg::MAX_ENTRIES)) n_m1 = 8'(falc_pkg::MAX_ENTRIES - 1);
    else n_m1 = 8'(entries - 9'd1);
  end

  assign go = (func == falc_pkg::FUNC_LOOKUP) ||
              (((func == falc_pkg::FUNC_INSERT) || (func == falc_pkg::FUNC_UPDATE)) && last_word);
  assign tick = enable && ((func == falc_pkg::FUNC_LOOKUP) ||
                           ((func == falc_pkg::FUNC_INSERT) && last_word));

  assign {q_disk, q_blk, q_stamp} = tag_q;
  assign rd_issue = (rd_idx <= {1'b0, n_m1});
  assign match    = cmp_vld && valid[cmp_idx] && (q_disk == disk_r) && (q_blk == blk_r);
  assign scan_end = cmp_vld && (cmp_idx == n_m1);
  assign act_tgt  = hit ? hit_slot : (free_ok ? free_idx : old_idx);

  always_ff @(posedge clk) begin
    if (rst) state <= falc_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      falc_pkg::S_IDLE: begin
        if (accept && go && enable) state_next = falc_pkg::S_SCAN;
      end
      falc_pkg::S_SCAN: begin
        if (match || scan_end) state_next = falc_pkg::S_ACT;
      end
      falc_pkg::S_ACT: begin
        if (func_r == falc_pkg::FUNC_LOOKUP) state_next = hit ? falc_pkg::S_READ : falc_pkg::S_IDLE;
        else if (func_r == falc_pkg::FUNC_UPDATE && !hit) state_next = falc_pkg::S_IDLE;
        else state_next = falc_pkg::S_COPY;
      end
      falc_pkg::S_COPY: begin
        if (cnt == 6'(falc_pkg::BLOCK_WORDS)) state_next = falc_pkg::S_IDLE;
      end
      falc_pkg::S_READ: begin
        if (cnt == 6'(falc_pkg::BLOCK_WORDS - 1)) state_next = falc_pkg::S_IDLE;
      end
      default: state_next = falc_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable  <= 1'b0;
      entries <= 9'd2;
      valid   <= '0;
      counter <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (wr_en) begin
        if (wr_index == falc_pkg::REG_ENABLE) begin
          enable <= wr_data[0];
          valid  <= '0;
        end else begin
          entries <= wr_data;
        end
      end
      if (accept && go) begin
        if (tick && counter < falc_pkg::STAMP_LIMIT) counter <= counter + 32'd1;
        if (!enable) done <= 1'b1;
      end
      if (state == falc_pkg::S_ACT) begin
        if (func_r == falc_pkg::FUNC_INSERT && !hit) valid[act_tgt] <= 1'b1;
        if (!hit && func_r != falc_pkg::FUNC_INSERT) done <= 1'b1;
      end
      if (state == falc_pkg::S_COPY && cnt == 6'(falc_pkg::BLOCK_WORDS)) done <= 1'b1;
      if (state == falc_pkg::S_READ) done <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      falc_pkg::S_IDLE: begin
        if (accept) begin
          func_r <= func;
          disk_r <= disk;
          blk_r  <= block_number;
          if (go && !enable) begin
            status         <= (func == falc_pkg::FUNC_UPDATE) ? falc_pkg::ST_MISS
                                                              : falc_pkg::ST_DISABLED;
            slot           <= '0;
            word_out_index <= '0;
            last_out       <= 1'b1;
            out_sel        <= 1'b0;
          end
        end
        rd_idx  <= '0;
        cmp_vld <= 1'b0;
        hit     <= 1'b0;
        free_ok <= 1'b0;
        oldest  <= '1;
        old_idx <= '0;
      end
      falc_pkg::S_SCAN: begin
        rd_idx  <= rd_idx + 9'd1;
        cmp_vld <= rd_issue && !match;
        cmp_idx <= rd_idx[falc_pkg::SLOT_W-1:0];
        if (match) begin
          hit      <= 1'b1;
          hit_slot <= cmp_idx;
        end
        if (cmp_vld) begin
          if (!valid[cmp_idx] && !free_ok) begin
            free_ok  <= 1'b1;
            free_idx <= cmp_idx;
          end
          if (q_stamp < oldest) begin
            oldest  <= q_stamp;
            old_idx <= cmp_idx;
          end
        end
      end
      falc_pkg::S_ACT: begin
        tgt <= act_tgt;
        cnt <= '0;
        res_status <= (func_r == falc_pkg::FUNC_INSERT && hit) ? falc_pkg::ST_PRESENT
                                                               : falc_pkg::ST_DONE;
        if (!hit && func_r != falc_pkg::FUNC_INSERT) begin
          status         <= falc_pkg::ST_MISS;
          slot           <= '0;
          word_out_index <= '0;
          last_out       <= 1'b1;
          out_sel        <= 1'b0;
        end
      end
      falc_pkg::S_COPY: begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(falc_pkg::BLOCK_WORDS)) begin
          status         <= res_status;
          slot           <= tgt;
          word_out_index <= '0;
          last_out       <= 1'b1;
          out_sel        <= 1'b0;
        end
      end
      falc_pkg::S_READ: begin
        cnt            <= cnt + 6'd1;
        status         <= falc_pkg::ST_DONE;
        slot           <= tgt;
        word_out_index <= cnt[falc_pkg::WIDX_W-1:0];
        last_out       <= (cnt == 6'(falc_pkg::BLOCK_WORDS - 1));
        out_sel        <= 1'b1;
      end
      default: ;
    endcase
  end

  // tag/stamp memory
  always_ff @(posedge clk) begin
    if (state == falc_pkg::S_SCAN && rd_issue)
      tag_q <= tag_mem[rd_idx[falc_pkg::SLOT_W-1:0]];
    if (state == falc_pkg::S_ACT && (hit || func_r == falc_pkg::FUNC_INSERT))
      tag_mem[act_tgt] <= {disk_r, blk_r, counter};
  end

  // staging buffer
  always_ff @(posedge clk) begin
    if (accept && (func == falc_pkg::FUNC_INSERT || func == falc_pkg::FUNC_UPDATE))
      stg_mem[word_index] <= data_word;
    if (state == falc_pkg::S_COPY && cnt != 6'(falc_pkg::BLOCK_WORDS))
      stg_q <= stg_mem[cnt[falc_pkg::WIDX_W-1:0]];
  end

  // block store
  always_ff @(posedge clk) begin
    if (state == falc_pkg::S_COPY && cnt != 6'd0)
      blk_mem[{tgt, 5'(cnt - 6'd1)}] <= stg_q;
    if (state == falc_pkg::S_READ)
      bs_q <= blk_mem[{tgt, cnt[falc_pkg::WIDX_W-1:0]}];
  end

endmodule

>>> hdl/falc_checker.sv
module falc_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [4:0]  word_out_index,
  input logic [63:0] data_out,
  input logic        last_out
);

  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    done && !last_out |=> done)
    else $error("hit run broken");

  a_run_index: assert property (@(posedge clk) disable iff (rst)
    done && !last_out |=> word_out_index == 5'($past(word_out_index) + 5'd1))
    else $error("hit run index not sequential");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    done && status != falc_pkg::ST_DONE |-> last_out && data_out == 64'd0 &&
    word_out_index == 5'd0)
    else $error("non-hit result malformed");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    done && !last_out |-> busy)
    else $error("idle during hit run");

endmodule

bind fully_assoc_lru_block_cache_core falc_checker u_falc_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .status(status),
  .word_out_index(word_out_index), .data_out(data_out), .last_out(last_out)
);
